// ===== src/mmpid_pkg.sv =====
// Shared types and constants of the four-motor PID speed controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package mmpid_pkg;

    localparam int MAX_REGS  = 4;
    localparam int DIV_STEPS = 7;

    localparam logic [15:0] GAIN_P_RESET = 16'd128;
    localparam logic [15:0] GAIN_I_RESET = 16'd26;
    localparam logic [15:0] GAIN_D_RESET = 16'd13;

    typedef enum logic [2:0] {
        REG_GAIN_P  = 3'd0,
        REG_GAIN_I  = 3'd1,
        REG_GAIN_D  = 3'd2,
        REG_MAX_SP0 = 3'd3,
        REG_MAX_SP1 = 3'd4,
        REG_MAX_SP2 = 3'd5,
        REG_MAX_SP3 = 3'd6,
        REG_NONE    = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_GATE,
        OP_SPEED,
        OP_ERR,
        OP_SUM,
        OP_MULP,
        OP_MULD,
        OP_MULI,
        OP_ADD,
        OP_ABS,
        OP_CLAMP,
        OP_DIV,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
    } dp_sts_t;

endpackage

// ===== src/multi_motor_pid_speed_control_core.sv =====
// Top level of the four-motor PID speed controller: APB register file, sequencer
// and datapath. Depends on mmpid_pkg, mmpid_ctrl and mmpid_dp.
//
// Usage: each input transfer names a motor, its target speed, its encoder count
// and the millisecond time. An update with an index at or above MOTOR_COUNT, or
// arriving less than UPDATE_INTERVAL_MS after that motor's last update, yields
// no result and frees the input again after the gate check. Otherwise one result
// transfer (motor, power in percent) follows, after the sequencer's single pass
// through the products and the seven-step restoring division into percent.
// The result sits in an output register; the input side is free again while it
// waits. If the receiver stalls, the next update runs and waits before writing
// its result until the earlier one has been taken. Gains and calibrated maximum
// speeds are to be written over APB only while the block is idle; the block
// itself does not enforce this. Reset clears all per-motor history and restores
// the default gains.
module multi_motor_pid_speed_control_core
    import mmpid_pkg::*;
#(
    parameter int MOTOR_COUNT        = 4,
    parameter int UPDATE_INTERVAL_MS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         motor_index,
    input  logic signed [20:0] speed_setpoint,
    input  logic signed [31:0] encoder_count,
    input  logic [31:0]        time_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         drive_motor,
    output logic signed [7:0]  drive_power,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]              gain_p_reg, gain_i_reg, gain_d_reg;
    logic [MAX_REGS-1:0][19:0] full_speed_reg;
    logic                     wr_en;
    reg_index_t               ridx;
    dp_cmd_t                  cmd;
    dp_sts_t                  sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= GAIN_P_RESET;
            gain_i_reg     <= GAIN_I_RESET;
            gain_d_reg     <= GAIN_D_RESET;
            full_speed_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (ridx)
                REG_GAIN_P:  gain_p_reg        <= pwdata[15:0];
                REG_GAIN_I:  gain_i_reg        <= pwdata[15:0];
                REG_GAIN_D:  gain_d_reg        <= pwdata[15:0];
                REG_MAX_SP0: full_speed_reg[0] <= pwdata[19:0];
                REG_MAX_SP1: full_speed_reg[1] <= pwdata[19:0];
                REG_MAX_SP2: full_speed_reg[2] <= pwdata[19:0];
                REG_MAX_SP3: full_speed_reg[3] <= pwdata[19:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_GAIN_P:  prdata = 32'(gain_p_reg);
            REG_GAIN_I:  prdata = 32'(gain_i_reg);
            REG_GAIN_D:  prdata = 32'(gain_d_reg);
            REG_MAX_SP0: prdata = 32'(full_speed_reg[0]);
            REG_MAX_SP1: prdata = 32'(full_speed_reg[1]);
            REG_MAX_SP2: prdata = 32'(full_speed_reg[2]);
            REG_MAX_SP3: prdata = 32'(full_speed_reg[3]);
            default:     prdata = '0;
        endcase
    end

    mmpid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mmpid_dp #(
        .MOTOR_COUNT        (MOTOR_COUNT),
        .UPDATE_INTERVAL_MS (UPDATE_INTERVAL_MS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .motor_index    (motor_index),
        .speed_setpoint (speed_setpoint),
        .encoder_count  (encoder_count),
        .time_ms        (time_ms),
        .gain_p         (gain_p_reg),
        .gain_i         (gain_i_reg),
        .gain_d         (gain_d_reg),
        .full_speed     (full_speed_reg),
        .drive_motor    (drive_motor),
        .drive_power    (drive_power)
    );

endmodule

// ===== src/mmpid_ctrl.sv =====
// Sequencer of the PID speed controller: steps the datapath through one update.
// Depends on mmpid_pkg for the command and status types.
module mmpid_ctrl
    import mmpid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE, S_GATE, S_SPEED, S_ERR, S_SUM, S_MULP, S_MULD,
        S_MULI, S_ADD, S_ABS, S_CLAMP, S_DIV, S_COMMIT
    } state_t;

    localparam int CW = $clog2(DIV_STEPS);

    state_t         state_reg, state_next;
    logic [CW-1:0]  div_cnt_reg, div_cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;

    assign out_free  = !(out_valid_reg && out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        cmd.op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_GATE;
                end
            end
            S_GATE:
            begin
                cmd.op     = OP_GATE;
                state_next = sts.skip ? S_IDLE : S_SPEED;
            end
            S_SPEED:
            begin
                cmd.op     = OP_SPEED;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.op     = OP_MULP;
                state_next = S_MULD;
            end
            S_MULD:
            begin
                cmd.op     = OP_MULD;
                state_next = S_MULI;
            end
            S_MULI:
            begin
                cmd.op     = OP_MULI;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.op     = OP_ABS;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.op       = OP_CLAMP;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // The result register is only overwritten once its transfer is done.
                if (out_free)
                begin
                    cmd.op         = OP_COMMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/mmpid_dp.sv =====
// Datapath of the PID speed controller: per-motor state, products, sums and
// the restoring division into percent. Depends on mmpid_pkg.
module mmpid_dp
    import mmpid_pkg::*;
#(
    parameter int MOTOR_COUNT        = 4,
    parameter int UPDATE_INTERVAL_MS = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_sts_t                     sts,
    input  logic [2:0]                  motor_index,
    input  logic signed [20:0]          speed_setpoint,
    input  logic signed [31:0]          encoder_count,
    input  logic [31:0]                 time_ms,
    input  logic [15:0]                 gain_p,
    input  logic [15:0]                 gain_i,
    input  logic [15:0]                 gain_d,
    input  logic [MAX_REGS-1:0][19:0]   full_speed,
    output logic [1:0]                  drive_motor,
    output logic signed [7:0]           drive_power
);

    localparam int AW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic signed [39:0] E_MAX = 40'sd2147483647;
    localparam logic signed [39:0] E_MIN = -40'sd2147483648;
    localparam logic signed [65:0] N_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] N_MIN = -66'sh0_8000_0000_0000_0000;

    // Per-motor state.
    logic signed [31:0] perr_mem [MOTOR_COUNT];
    logic signed [47:0] esum_mem [MOTOR_COUNT];
    logic [31:0]        pcnt_mem [MOTOR_COUNT];
    logic [31:0]        ptim_mem [MOTOR_COUNT];

    // Working registers of one update.
    logic [2:0]         idx_reg;
    logic signed [20:0] target_reg;
    logic signed [31:0] count_reg;
    logic [31:0]        now_reg;
    logic signed [31:0] delta_reg, perr_reg, err_reg;
    logic signed [47:0] esum_reg, sum_reg;
    logic [19:0]        maxs_reg;
    logic signed [38:0] speed_reg;
    logic [22:0]        kp_reg;
    logic [29:0]        kd_reg;
    logic signed [32:0] derr_reg;
    logic signed [63:0] pterm_reg, dterm_reg, iterm_reg, num_reg;
    logic [63:0]        rem_reg;
    logic [33:0]        dsh_reg;
    logic               neg_reg, zero_reg, fixed_reg;
    logic [6:0]         fmag_reg, q_reg;
    logic [1:0]         motor_reg;
    logic signed [7:0]  power_reg;

    logic [AW-1:0]      ai;
    logic               in_range;
    logic [31:0]        elapsed;
    logic signed [39:0] ediff;
    logic signed [48:0] esum_new;
    logic signed [55:0] pprod;
    logic signed [63:0] dprod, iprod;
    logic signed [65:0] ntot;
    logic [34:0]        dlim;
    logic [6:0]         mag;

    assign ai       = idx_reg[AW-1:0];
    assign in_range = ({1'b0, idx_reg} < 4'(MOTOR_COUNT));
    assign elapsed  = now_reg - ptim_mem[ai];
    assign sts.skip = !(in_range && (elapsed >= 32'(UPDATE_INTERVAL_MS)));

    assign ediff    = 40'(target_reg) - 40'(speed_reg);
    assign esum_new = 49'(esum_reg) + 49'(err_reg);
    assign pprod    = err_reg * $signed({1'b0, kp_reg});
    assign dprod    = derr_reg * $signed({1'b0, kd_reg});
    assign iprod    = sum_reg * $signed({1'b0, gain_i});
    assign ntot     = 66'(pterm_reg) + 66'(dterm_reg) + 66'(iterm_reg);
    assign dlim     = 35'(maxs_reg) * 35'd25600;
    assign mag      = fixed_reg ? fmag_reg : q_reg;

    assign drive_motor = motor_reg;
    assign drive_power = power_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= motor_index;
            target_reg <= speed_setpoint;
            count_reg  <= encoder_count;
            now_reg    <= time_ms;
        end
        case (cmd.op)
            OP_GATE:
            begin
                delta_reg <= count_reg - $signed(pcnt_mem[ai]);
                perr_reg  <= perr_mem[ai];
                esum_reg  <= esum_mem[ai];
                maxs_reg  <= ({1'b0, idx_reg} < 4'(MAX_REGS)) ? full_speed[idx_reg[1:0]] : '0;
            end
            OP_SPEED:
            begin
                speed_reg <= 39'(delta_reg) * 39'sd100;
                kp_reg    <= 23'(gain_p) * 23'd100;
                kd_reg    <= 30'(gain_d) * 30'd10000;
            end
            OP_ERR:
            begin
                if (ediff > E_MAX)
                begin
                    err_reg <= E_MAX[31:0];
                end
                else if (ediff < E_MIN)
                begin
                    err_reg <= E_MIN[31:0];
                end
                else
                begin
                    err_reg <= ediff[31:0];
                end
            end
            OP_SUM:
            begin
                // A carry into the top bit that disagrees with the next marks overflow.
                if (esum_new[48] != esum_new[47])
                begin
                    sum_reg <= esum_new[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                end
                else
                begin
                    sum_reg <= esum_new[47:0];
                end
                derr_reg <= 33'(err_reg) - 33'(perr_reg);
            end
            OP_MULP:
            begin
                pterm_reg <= 64'(pprod);
            end
            OP_MULD:
            begin
                dterm_reg <= dprod;
            end
            OP_MULI:
            begin
                iterm_reg <= iprod;
            end
            OP_ADD:
            begin
                if (ntot > N_MAX)
                begin
                    num_reg <= N_MAX[63:0];
                end
                else if (ntot < N_MIN)
                begin
                    num_reg <= N_MIN[63:0];
                end
                else
                begin
                    num_reg <= ntot[63:0];
                end
            end
            OP_ABS:
            begin
                neg_reg  <= num_reg[63];
                zero_reg <= (num_reg == '0);
                rem_reg  <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
            end
            OP_CLAMP:
            begin
                // With no calibration the sign alone decides; otherwise a quotient of
                // a hundred or more saturates, and the division's quotient is not used.
                q_reg   <= '0;
                dsh_reg <= {maxs_reg, 14'd0};
                if (maxs_reg == '0)
                begin
                    fixed_reg <= 1'b1;
                    fmag_reg  <= zero_reg ? 7'd0 : 7'd100;
                end
                else if (rem_reg >= 64'(dlim))
                begin
                    fixed_reg <= 1'b1;
                    fmag_reg  <= 7'd100;
                end
                else
                begin
                    fixed_reg <= 1'b0;
                    fmag_reg  <= 7'd0;
                end
            end
            OP_DIV:
            begin
                if (rem_reg >= 64'(dsh_reg))
                begin
                    rem_reg <= rem_reg - 64'(dsh_reg);
                    q_reg   <= {q_reg[5:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[5:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_COMMIT:
            begin
                motor_reg <= idx_reg[1:0];
                power_reg <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MOTOR_COUNT; k++)
            begin
                perr_mem[k] <= '0;
                esum_mem[k] <= '0;
                pcnt_mem[k] <= '0;
                ptim_mem[k] <= '0;
            end
        end
        else if (cmd.op == OP_COMMIT)
        begin
            perr_mem[ai] <= err_reg;
            esum_mem[ai] <= sum_reg;
            pcnt_mem[ai] <= count_reg;
            ptim_mem[ai] <= now_reg;
        end
    end

endmodule

// ===== src/mmpid_checker.sv =====
// Port-level checks of the PID speed controller, bound to the top level.
// Depends only on the ports of multi_motor_pid_speed_control_core.
module mmpid_checker
#(
    parameter int MOTOR_COUNT = 4
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [2:0]        motor_index,
    input logic              out_valid,
    input logic              out_stall,
    input logic [1:0]        drive_motor,
    input logic signed [7:0] drive_power
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_motor) && $stable(drive_power))
        else $error("result changed or vanished while stalled");

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_power <= 8'sd100) && (drive_power >= -8'sd100))
        else $error("drive power outside plus or minus 100");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again straight after a transfer");

    a_bad_index_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ({1'b0, motor_index} >= 4'(MOTOR_COUNT)) |=> ##1 !in_stall)
        else $error("ignored index held the input busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an update in progress");

endmodule

bind multi_motor_pid_speed_control_core mmpid_checker #(
    .MOTOR_COUNT (MOTOR_COUNT)
) u_mmpid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .motor_index (motor_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_motor (drive_motor),
    .drive_power (drive_power)
);

// ===== tb/sv/multi_motor_pid_speed_control_core_test.sv =====
// Self-checking testbench of the four-motor PID speed controller.
// Drives speed requests and APB writes, predicts each power result and checks it.
// Depends on mmpid_pkg and multi_motor_pid_speed_control_core.
`timescale 1ns / 100ps

class pid_power_board;
    logic [15:0] kp, ki, kd;
    logic [19:0] top_speed [4];
    longint      last_err  [8];
    longint      err_total [8];
    logic [31:0] last_cnt  [8];
    logic [31:0] last_ms   [8];
    logic [9:0]  pending_power [$];
    int          fault_count;

    function new();
        kp = 16'd128;
        ki = 16'd26;
        kd = 16'd13;
        fault_count = 0;
        for (int k = 0; k < 4; k++)
            top_speed[k] = '0;
        for (int k = 0; k < 8; k++)
        begin
            last_err[k] = 0;
            err_total[k] = 0;
            last_cnt[k] = '0;
            last_ms[k] = '0;
        end
    endfunction

    function void set_reg(int idx, logic [31:0] v);
        if (idx == 0) kp = v[15:0];
        else if (idx == 1) ki = v[15:0];
        else if (idx == 2) kd = v[15:0];
        else if (idx >= 3 && idx <= 6) top_speed[idx - 3] = v[19:0];
    endfunction

    function longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Notes a request taken by the block and queues the power it must produce.
    function void note_request(logic [2:0] m, logic signed [20:0] tgt,
                               logic [31:0] cnt, logic [31:0] now);
        logic [31:0] gap;
        logic [31:0] du;
        longint delta, e, s, dterm, pterm, iterm, num, pw, ms;
        if (m >= 4) return;
        gap = now - last_ms[m];
        if (gap < 32'd10) return;
        du = cnt - last_cnt[m];
        delta = longint'(signed'(du));
        e = clip(longint'(tgt) - delta * 100, -64'sd2147483648, 64'sd2147483647);
        s = clip(err_total[m] + e, -64'sd140737488355328, 64'sd140737488355327);
        dterm = longint'(kd) * (e - last_err[m]) * 10000;
        pterm = longint'(kp) * e * 100 + dterm;
        iterm = longint'(ki) * s;
        if (pterm > 0 && iterm > 64'sh7FFFFFFFFFFFFFFF - pterm)
            num = 64'sh7FFFFFFFFFFFFFFF;
        else if (pterm < 0 && iterm < -64'sh7FFFFFFFFFFFFFFF - 1 - pterm)
            num = -64'sh7FFFFFFFFFFFFFFF - 1;
        else
            num = pterm + iterm;
        ms = longint'(top_speed[m]);
        if (ms == 0)
            pw = (num > 0) ? 100 : ((num < 0) ? -100 : 0);
        else
            pw = clip(num / (256 * ms), -100, 100);
        last_err[m] = e;
        err_total[m] = s;
        last_cnt[m] = cnt;
        last_ms[m] = now;
        pending_power.push_back({m[1:0], pw[7:0]});
    endfunction

    function void check_power(logic [1:0] mot, logic [7:0] pw);
        logic [9:0] exp_r;
        if (pending_power.size() == 0)
        begin
            $error("drive result with none pending: motor %0d power %0d", mot, $signed(pw));
            fault_count++;
            return;
        end
        exp_r = pending_power.pop_front();
        if (exp_r[9:8] !== mot)
        begin
            $error("drive_motor expected %0d actual %0d", exp_r[9:8], mot);
            fault_count++;
        end
        if (exp_r[7:0] !== pw)
        begin
            $error("drive_power expected %0d actual %0d", $signed(exp_r[7:0]), $signed(pw));
            fault_count++;
        end
    endfunction
endclass

module multi_motor_pid_speed_control_core_test;
    import mmpid_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         motor_index;
    logic signed [20:0] speed_setpoint;
    logic signed [31:0] encoder_count;
    logic [31:0]        time_ms;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         drive_motor;
    logic signed [7:0]  drive_power;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    pid_power_board board;
    logic [31:0] clock_ms [4];
    logic [31:0] enc_pos  [4];
    bit          long_hold;
    bit          stim_done;

    multi_motor_pid_speed_control_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, with one long hold-off on request.
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            wait_n = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) wait_n = 0;
            out_stall = (wait_n != 0);
            if (wait_n != 0)
            begin
                repeat (wait_n - 1) @(negedge clk);
                @(negedge clk);
                out_stall = 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            board.check_power(drive_motor, drive_power);
        end
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, v);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_request(input logic [2:0] m, input logic signed [20:0] tgt,
                                input logic [31:0] cnt, input logic [31:0] now,
                                input int gap);
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        motor_index = m;
        speed_setpoint = tgt;
        encoder_count = cnt;
        time_ms = now;
        do @(posedge clk); while (in_stall);
        board.note_request(m, tgt, cnt, now);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // A plausible update: time moves on by about the interval and the count
    // tracks a speed in the same range as the target.
    task automatic send_update(input int gap);
        logic [2:0] m;
        logic signed [20:0] tgt;
        m = $urandom_range(0, 3);
        clock_ms[m] = clock_ms[m] + $urandom_range(8, 14);
        enc_pos[m] = enc_pos[m] + $urandom_range(0, 800) - 400;
        tgt = $urandom_range(0, 80000) - 40000;
        send_request(m, tgt, enc_pos[m], clock_ms[m], gap);
    endtask

    task automatic send_noise(input int gap);
        send_request($urandom, $urandom, $urandom, $urandom, gap);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        while (board.pending_power.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            int gap;
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 7);
            if (n > count / 2 && n < count / 2 + 30) gap = 0;
            if ($urandom_range(0, 9) == 0)
                send_noise(gap);
            else
                send_update(gap);
        end
    endtask

    initial
    begin
        in_valid = 1'b0;
        motor_index = '0;
        speed_setpoint = '0;
        encoder_count = '0;
        time_ms = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        board = new();
        for (int k = 0; k < 4; k++)
        begin
            clock_ms[k] = 32'd0;
            enc_pos[k] = 32'd0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero maximum speed, too soon, out of range, extremes.
        send_request(3'd0, 21'sd1000, 32'd0, 32'd5, 0);
        send_request(3'd0, 21'sd1000, 32'd3, 32'd10, 0);
        send_request(3'd0, 21'sd1000, 32'd3, 32'd19, 0);
        send_request(3'd5, 21'sd1000, 32'd3, 32'd100, 0);
        send_request(3'd7, -21'sd1048576, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
        send_request(3'd1, 21'sd1048575, 32'h7FFFFFFF, 32'd20, 1);
        send_request(3'd1, -21'sd1048576, 32'h80000000, 32'd40, 2);
        send_request(3'd2, 21'sd0, 32'd0, 32'd30, 0);
        send_request(3'd2, 21'sd0, 32'd0, 32'hFFFFFFFF, 0);
        send_request(3'd2, 21'sd0, 32'd0, 32'd8, 0);
        send_request(3'd3, 21'sd0, 32'hFFFFFFFF, 32'hFFFFFFF0, 3);
        drain();

        apb_write(REG_MAX_SP0, 32'hFFFFF);
        apb_write(REG_MAX_SP1, 32'd1);
        apb_write(REG_MAX_SP2, 32'd50000);
        apb_write(REG_MAX_SP3, 32'd0);
        send_request(3'd0, 21'sd1048575, 32'h7FFFFFFF, 32'd100, 0);
        send_request(3'd1, 21'sd5, 32'h7FFFFFFF, 32'd200, 0);
        send_request(3'd2, -21'sd30000, 32'd100, 32'd300, 0);
        send_request(3'd3, 21'sd12, 32'd0, 32'hFFFFFFF0 + 32'd20, 0);
        for (int k = 0; k < 4; k++)
            clock_ms[k] = 32'd1000;
        drain();

        // The sender waits here while the receiver holds off.
        long_hold = 1'b1;
        random_phase(350);
        drain();

        apb_write(REG_GAIN_P, 32'hFFFF);
        apb_write(REG_GAIN_I, 32'h0);
        apb_write(REG_GAIN_D, 32'hFFFF);
        apb_write(REG_MAX_SP0, 32'd20000);
        apb_write(REG_MAX_SP1, 32'd400000);
        apb_write(REG_MAX_SP2, 32'd3000);
        apb_write(REG_MAX_SP3, 32'd90000);
        random_phase(350);
        drain();

        apb_write(REG_GAIN_P, 32'h0);
        apb_write(REG_GAIN_I, 32'hFFFF);
        apb_write(REG_GAIN_D, 32'h0);
        apb_write(REG_MAX_SP3, 32'hFFFFF);
        random_phase(350);
        drain();

        apb_write(REG_GAIN_P, $urandom);
        apb_write(REG_GAIN_I, $urandom);
        apb_write(REG_GAIN_D, $urandom);
        apb_write(REG_MAX_SP0, $urandom);
        apb_write(REG_MAX_SP2, 32'd0);
        long_hold = 1'b1;
        random_phase(350);
        drain();

        if (board.fault_count == 0 && board.pending_power.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
src/mmpid_pkg.sv
src/mmpid_ctrl.sv
src/mmpid_dp.sv
src/multi_motor_pid_speed_control_core.sv
src/mmpid_checker.sv
tb/sv/multi_motor_pid_speed_control_core_test.sv
